// ===== src/bpq_pkg.sv =====
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared types and constants for the bitmap priority ready queue.
// ----------------------------------------------------------------------------
package bpq_pkg;

  localparam int DEF_NUM_LEVELS = 64;
  localparam int DEF_NUM_JOBS   = 64;
  localparam int JOB_ID_W       = 6;
  localparam int LEVEL_W        = 6;
  localparam int ID_SLOTS       = 64;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_NEXT   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ERR   = 2'd2
  } status_t;

  // link to a neighbor job; none set means end of list
  typedef struct packed {
    logic                none;
    logic [JOB_ID_W-1:0] id;
  } link_t;

  typedef struct packed {
    link_t              nxt;
    link_t              prv;
    logic [LEVEL_W-1:0] lvl;
  } job_entry_t;

  typedef struct packed {
    logic nxt;
    logic prv;
    logic lvl;
  } job_wen_t;

  typedef struct packed {
    logic [JOB_ID_W-1:0] head;
    logic [JOB_ID_W-1:0] tail;
  } level_entry_t;

  typedef struct packed {
    logic head;
    logic tail;
  } level_wen_t;

endpackage

// ===== src/bpq_job_mem.sv =====
// ----------------------------------------------------------------------------
// bpq_job_mem
// Per-job link table: next, previous and level, with field write enables.
// ----------------------------------------------------------------------------
module bpq_job_mem
  import bpq_pkg::*;
#(
  parameter int DEPTH = DEF_NUM_JOBS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output job_entry_t       rdata,
  input  job_wen_t         wen,
  input  logic [AW-1:0]    waddr,
  input  job_entry_t       wdata
);

  link_t              nxt_mem [DEPTH];
  link_t              prv_mem [DEPTH];
  logic [LEVEL_W-1:0] lvl_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen.nxt) begin
      nxt_mem[waddr] <= wdata.nxt;
    end
    if (wen.prv) begin
      prv_mem[waddr] <= wdata.prv;
    end
    if (wen.lvl) begin
      lvl_mem[waddr] <= wdata.lvl;
    end
    if (re) begin
      rdata <= '{nxt: nxt_mem[raddr], prv: prv_mem[raddr], lvl: lvl_mem[raddr]};
    end
  end

endmodule

// ===== src/bpq_level_mem.sv =====
// ----------------------------------------------------------------------------
// bpq_level_mem
// Per-level head and tail table, with field write enables.
// ----------------------------------------------------------------------------
module bpq_level_mem
  import bpq_pkg::*;
#(
  parameter int DEPTH = DEF_NUM_LEVELS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output level_entry_t  rdata,
  input  level_wen_t    wen,
  input  logic [AW-1:0] waddr,
  input  level_entry_t  wdata
);

  logic [JOB_ID_W-1:0] head_mem [DEPTH];
  logic [JOB_ID_W-1:0] tail_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen.head) begin
      head_mem[waddr] <= wdata.head;
    end
    if (wen.tail) begin
      tail_mem[waddr] <= wdata.tail;
    end
    if (re) begin
      rdata <= '{head: head_mem[raddr], tail: tail_mem[raddr]};
    end
  end

endmodule

// ===== src/bitmap_priority_ready_queue.sv =====
// ----------------------------------------------------------------------------
// bitmap_priority_ready_queue
// Multilevel FIFO ready queue with a ready bitmask and linked job tables.
// ----------------------------------------------------------------------------
//  channel | ports      | fields (lsb first)
//  input   | in_t*      | opcode[1:0] job_id[7:2] priority_req[13:8]
//  result  | out_t*     | picked_job[5:0] picked_level[11:6] status[13:12]
//
//  One request at a time. Errors and empty pops go straight to the result; an
//  add reads the level entry, then writes the job and links a ready level's
//  old tail to it; a remove reads the job, a pop the top level's head and then
//  the job, and both unlink it and fix a successor's back link, in steps set
//  by the registered memory reads and the single write port of the job table.
//  Reset clears the ready mask and the queued flags; the tables need no clearing.
//  A held result does not block the next request until that request finishes.
// ----------------------------------------------------------------------------
module bitmap_priority_ready_queue
  import bpq_pkg::*;
#(
  parameter int NUM_LEVELS = DEF_NUM_LEVELS,
  parameter int NUM_JOBS   = DEF_NUM_JOBS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // opcode, job_id, priority_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // picked_job, picked_level, status
);

  localparam int JOB_DEPTH = (NUM_JOBS < ID_SLOTS) ? NUM_JOBS : ID_SLOTS;
  localparam int JW        = $clog2(JOB_DEPTH);
  localparam int LW        = $clog2(NUM_LEVELS);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ADD  = 7'b0000010,
    S_ADD2 = 7'b0000100,
    S_NXT  = 7'b0001000,
    S_UNL  = 7'b0010000,
    S_UNL2 = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [NUM_LEVELS-1:0] mask_r, mask_nxt;
  logic [JOB_DEPTH-1:0]  queued_r, queued_nxt;
  opcode_t             op_r, op_nxt;
  logic [JOB_ID_W-1:0] id_r, id_nxt;
  logic [LEVEL_W-1:0]  pr_r, pr_nxt;
  logic [LEVEL_W-1:0]  lv_r, lv_nxt;
  logic [JOB_ID_W-1:0] pj_r, pj_nxt;
  logic [LEVEL_W-1:0]  pl_r, pl_nxt;
  status_t             st_r, st_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [15:0]         out_data_r, out_data_nxt;

  opcode_t             in_op;
  logic [JOB_ID_W-1:0] in_id;
  logic [LEVEL_W-1:0]  in_pr;
  logic                id_ok, pr_ok, in_queued;
  logic [LEVEL_W-1:0]  top_lv;
  logic [LEVEL_W-1:0]  unl_lv;

  logic          job_re, lvl_re;
  logic [JW-1:0] job_raddr, job_waddr;
  logic [LW-1:0] lvl_raddr, lvl_waddr;
  job_entry_t    job_rd, job_wd;
  level_entry_t  lvl_rd, lvl_wd;
  job_wen_t      job_wen;
  level_wen_t    lvl_wen;

  bpq_job_mem #(.DEPTH(JOB_DEPTH), .AW(JW)) u_job_mem (
    .clk   (clk),
    .re    (job_re),
    .raddr (job_raddr),
    .rdata (job_rd),
    .wen   (job_wen),
    .waddr (job_waddr),
    .wdata (job_wd)
  );

  bpq_level_mem #(.DEPTH(NUM_LEVELS), .AW(LW)) u_level_mem (
    .clk   (clk),
    .re    (lvl_re),
    .raddr (lvl_raddr),
    .rdata (lvl_rd),
    .wen   (lvl_wen),
    .waddr (lvl_waddr),
    .wdata (lvl_wd)
  );

  assign in_op     = opcode_t'(in_tdata[1:0]);
  assign in_id     = in_tdata[7:2];
  assign in_pr     = in_tdata[13:8];
  assign id_ok     = 11'(in_id) < 11'(NUM_JOBS);
  assign pr_ok     = 7'(in_pr) < 7'(NUM_LEVELS);
  assign in_queued = id_ok && queued_r[in_id[JW-1:0]];
  assign unl_lv    = (op_r == OP_REMOVE) ? job_rd.lvl : lv_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // highest ready level
  always_comb begin
    top_lv = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (mask_r[i]) begin
        top_lv = LEVEL_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mask_nxt      = mask_r;
    queued_nxt    = queued_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    pr_nxt        = pr_r;
    lv_nxt        = lv_r;
    pj_nxt        = pj_r;
    pl_nxt        = pl_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    job_re        = 1'b0;
    job_raddr     = in_id[JW-1:0];
    lvl_re        = 1'b0;
    lvl_raddr     = in_pr[LW-1:0];
    job_wen       = '0;
    job_waddr     = id_r[JW-1:0];
    job_wd        = '0;
    lvl_wen       = '0;
    lvl_waddr     = pr_r[LW-1:0];
    lvl_wd        = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt = in_op;
          id_nxt = in_id;
          pr_nxt = in_pr;
          pj_nxt = in_id;
          pl_nxt = '0;
          st_nxt = ST_ERR;
          state_nxt = S_DONE;
          unique case (in_op)
            OP_ADD: begin
              pl_nxt = in_pr;
              if (id_ok && pr_ok && !in_queued) begin
                lvl_re    = 1'b1;
                state_nxt = S_ADD;
              end
            end
            OP_NEXT: begin
              if (|mask_r) begin
                lv_nxt    = top_lv;
                lvl_re    = 1'b1;
                lvl_raddr = top_lv[LW-1:0];
                state_nxt = S_NXT;
              end else begin
                st_nxt = ST_EMPTY;
              end
            end
            OP_REMOVE: begin
              if (id_ok && in_queued) begin
                job_re    = 1'b1;
                state_nxt = S_UNL;
              end
            end
            default: begin
              st_nxt = ST_ERR;
            end
          endcase
        end
      end

      S_ADD: begin
        job_wen     = '{nxt: 1'b1, prv: 1'b1, lvl: 1'b1};
        job_wd.nxt  = '{none: 1'b1, id: '0};
        job_wd.lvl  = pr_r;
        lvl_wd.tail = id_r;
        lvl_wd.head = id_r;
        lvl_wen.tail = 1'b1;
        if (mask_r[pr_r[LW-1:0]]) begin
          job_wd.prv = '{none: 1'b0, id: lvl_rd.tail};
          state_nxt  = S_ADD2;
        end else begin
          job_wd.prv   = '{none: 1'b1, id: '0};
          lvl_wen.head = 1'b1;
          state_nxt    = S_DONE;
        end
        mask_nxt[pr_r[LW-1:0]]  = 1'b1;
        queued_nxt[id_r[JW-1:0]] = 1'b1;
        st_nxt = ST_OK;
      end

      S_ADD2: begin
        // link the old tail forward to the new job
        job_wen.nxt = 1'b1;
        job_waddr   = lvl_rd.tail[JW-1:0];
        job_wd.nxt  = '{none: 1'b0, id: id_r};
        state_nxt   = S_DONE;
      end

      S_NXT: begin
        pj_nxt    = lvl_rd.head;
        pl_nxt    = lv_r;
        job_re    = 1'b1;
        job_raddr = lvl_rd.head[JW-1:0];
        state_nxt = S_UNL;
      end

      S_UNL: begin
        lvl_waddr   = unl_lv[LW-1:0];
        lvl_wd.head = job_rd.nxt.id;
        lvl_wd.tail = job_rd.prv.id;
        if (!job_rd.prv.none) begin
          job_wen.nxt = 1'b1;
          job_waddr   = job_rd.prv.id[JW-1:0];
          job_wd.nxt  = job_rd.nxt;
        end else if (!job_rd.nxt.none) begin
          lvl_wen.head = 1'b1;
        end
        if (job_rd.nxt.none && !job_rd.prv.none) begin
          lvl_wen.tail = 1'b1;
        end
        if (job_rd.nxt.none && job_rd.prv.none) begin
          mask_nxt[unl_lv[LW-1:0]] = 1'b0;
        end
        queued_nxt[pj_r[JW-1:0]] = 1'b0;
        pl_nxt    = unl_lv;
        st_nxt    = ST_OK;
        state_nxt = job_rd.nxt.none ? S_DONE : S_UNL2;
      end

      S_UNL2: begin
        job_wen.prv = 1'b1;
        job_waddr   = job_rd.nxt.id[JW-1:0];
        job_wd.prv  = job_rd.prv;
        state_nxt   = S_DONE;
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, st_r, pl_r, pj_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mask_r      <= '0;
      queued_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      queued_r    <= queued_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    pr_r       <= pr_nxt;
    lv_r       <= lv_nxt;
    pj_r       <= pj_nxt;
    pl_r       <= pl_nxt;
    st_r       <= st_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
